[rtl/segtree_pkg.sv]
package segtree_pkg;

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int AMOUNT_W = 32;
	localparam int SUM_W = 42;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_WITHDRAW  = 2'd1,
		OP_DEPOSIT   = 2'd2,
		OP_RANGE_SUM = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 operation;
		logic [INDEX_W-1:0]  item_index;
		logic [AMOUNT_W-1:0] amount;
		logic [INDEX_W-1:0]  range_low;
		logic [INDEX_W-1:0]  range_high;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic [SUM_W-1:0] result_value;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_LEAF_RD,
		ST_LEAF_WR,
		ST_UP,
		ST_QUERY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear_step;
		logic leaf_read;
		logic leaf_write;
		logic up_step;
		logic q_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic item_bad;
		op_t  op;
		logic up_last;
		logic q_more;
	} stat_t;

endpackage

[rtl/segment_tree_point_update_range_sum.sv]
// Point-update, range-sum segment tree over LEAVES leaves, kept bottom-up in one
// node memory of 2*LEAVES words with a single write port and two registered read
// ports. After reset the block sweeps the memory to zero, one word per cycle,
// and accepts no transaction until the sweep ends; element_count writes are
// taken at any time. Each transaction returns one result. Load, withdraw and
// deposit read the leaf, write it, then climb one level per cycle repairing the
// ancestors. A range sum fetches up to two nodes per level. Rejected
// transactions (index out of range) skip the tree and go straight to the
// result register. The rate is set by the walk of one tree level at a time
// through the memory ports. The result sits in an output register, so a new
// transaction is accepted while the last result waits.
module segment_tree_point_update_range_sum #(
	parameter int LEAVES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  segtree_pkg::in_item_t           in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output segtree_pkg::out_item_t          out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [segtree_pkg::COUNT_W-1:0] cfg_data
);

	segtree_pkg::cmd_t  cmd;
	segtree_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	segtree_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	segtree_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

[rtl/segtree_dp.sv]
module segtree_dp #(
	parameter int LEAVES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  segtree_pkg::cmd_t                  cmd,
	output segtree_pkg::stat_t                 stat,
	input  segtree_pkg::in_item_t              in_data,
	input  logic                               cfg_write,
	input  logic [segtree_pkg::COUNT_W-1:0]    cfg_data,
	output segtree_pkg::out_item_t             out_data
);

	localparam int DEPTH = 2 * LEAVES;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam int SW = segtree_pkg::SUM_W;
	localparam int LW = segtree_pkg::AMOUNT_W;

	logic [SW-1:0] mem [DEPTH];

	logic [segtree_pkg::COUNT_W-1:0] count_q;
	logic [AW-1:0]                   clr_q;
	segtree_pkg::op_t                op_q;
	logic [LW-1:0]                   amount_q;
	logic                            bad_q;
	logic [AW-1:0]                   pos_q;
	logic [SW-1:0]                   cur_q;
	logic [PW-1:0]                   l_q;
	logic [PW-1:0]                   r_q;
	logic [SW-1:0]                   acc_q;
	logic                            take_a_q;
	logic                            take_b_q;
	logic [SW-1:0]                   res_q;
	logic [SW-1:0]                   rda_q;
	logic [SW-1:0]                   rdb_q;
	segtree_pkg::out_item_t          out_q;

	logic          idx_ok;
	logic          lo_ok;
	logic          hi_ok;
	logic [AW-1:0] pos_up;
	logic [LW:0]   dep_sum;
	logic [LW-1:0] leaf_new;
	logic [SW-1:0] parent_sum;
	logic          q_more;
	logic [PW-1:0] r_dec;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [SW-1:0] wr_data;
	logic          rda_en;
	logic [AW-1:0] rda_addr;
	logic          rdb_en;

	assign idx_ok = (32'(in_data.item_index) < 32'(count_q))
		&& (32'(in_data.item_index) < 32'(LEAVES));
	assign lo_ok = (32'(in_data.range_low) < 32'(count_q))
		&& (32'(in_data.range_low) < 32'(LEAVES));
	assign hi_ok = (32'(in_data.range_high) < 32'(count_q))
		&& (32'(in_data.range_high) < 32'(LEAVES));

	assign pos_up = pos_q >> 1;
	assign dep_sum = {1'b0, rda_q[LW-1:0]} + {1'b0, amount_q};
	assign parent_sum = cur_q + rda_q;
	assign q_more = l_q < r_q;
	assign r_dec = r_q - PW'(1);

	always_comb begin
		case (op_q)
			segtree_pkg::OP_LOAD:     leaf_new = amount_q;
			segtree_pkg::OP_WITHDRAW: leaf_new = '0;
			segtree_pkg::OP_DEPOSIT:  leaf_new = dep_sum[LW] ? '1 : dep_sum[LW-1:0];
			default:                  leaf_new = amount_q;
		endcase
	end

	// one write port shared by the clearing pass, the leaf write and the repair walk
	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clear_step) begin
			wr_en = 1'b1;
		end else if (cmd.leaf_write) begin
			wr_en = 1'b1;
			wr_addr = pos_q;
			wr_data = SW'(leaf_new);
		end else if (cmd.up_step) begin
			wr_en = 1'b1;
			wr_addr = pos_up;
			wr_data = parent_sum;
		end
	end

	always_comb begin
		rda_en = 1'b0;
		rda_addr = pos_q;
		if (cmd.leaf_read) begin
			rda_en = 1'b1;
		end else if (cmd.leaf_write) begin
			rda_en = 1'b1;
			rda_addr = pos_q ^ AW'(1);
		end else if (cmd.up_step) begin
			rda_en = 1'b1;
			rda_addr = pos_up ^ AW'(1);
		end else if (cmd.q_step && q_more) begin
			rda_en = 1'b1;
			rda_addr = l_q[AW-1:0];
		end
	end

	assign rdb_en = cmd.q_step && q_more;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rda_en) begin
			rda_q <= mem[rda_addr];
		end
		if (rdb_en) begin
			rdb_q <= mem[r_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= segtree_pkg::COUNT_RESET;
			clr_q <= '0;
		end else begin
			if (cfg_write) begin
				count_q <= cfg_data;
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_data.operation;
			amount_q <= in_data.amount;
			if (in_data.operation == segtree_pkg::OP_RANGE_SUM) begin
				bad_q <= !(lo_ok && hi_ok);
			end else begin
				bad_q <= !idx_ok;
			end
			pos_q <= AW'(in_data.item_index) + AW'(LEAVES);
			l_q <= PW'(in_data.range_low) + PW'(LEAVES);
			r_q <= PW'(in_data.range_high) + PW'(LEAVES) + PW'(1);
			acc_q <= '0;
			take_a_q <= 1'b0;
			take_b_q <= 1'b0;
			res_q <= '0;
		end
		if (cmd.leaf_write) begin
			cur_q <= SW'(leaf_new);
			if (op_q == segtree_pkg::OP_WITHDRAW) begin
				res_q <= rda_q;
			end
		end
		if (cmd.up_step) begin
			cur_q <= parent_sum;
			pos_q <= pos_up;
		end
		if (cmd.q_step) begin
			// fold in the nodes fetched last cycle, then climb one level
			acc_q <= acc_q + (take_a_q ? rda_q : '0) + (take_b_q ? rdb_q : '0);
			if (q_more) begin
				take_a_q <= l_q[0];
				take_b_q <= r_q[0];
				l_q <= (l_q >> 1) + PW'(l_q[0]);
				r_q <= r_q >> 1;
			end else begin
				take_a_q <= 1'b0;
				take_b_q <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			out_q.status <= bad_q;
			if (bad_q) begin
				out_q.result_value <= '0;
			end else if (op_q == segtree_pkg::OP_RANGE_SUM) begin
				out_q.result_value <= acc_q;
			end else begin
				out_q.result_value <= res_q;
			end
		end
	end

	assign out_data = out_q;

	assign stat.clear_last = clr_q == AW'(DEPTH - 1);
	assign stat.item_bad = bad_q;
	assign stat.op = op_q;
	assign stat.up_last = pos_q[AW-1:1] == (AW-1)'(1);
	assign stat.q_more = q_more;

	a_up_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_step |-> pos_q > AW'(1))
		else $error("repair step issued at the root");

	a_leaf_in_leaf_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.leaf_write |-> pos_q >= AW'(LEAVES))
		else $error("leaf write outside the leaf row");

	a_query_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.q_step && q_more) |-> r_q <= PW'(DEPTH))
		else $error("query right bound beyond the store");

endmodule

[rtl/segtree_ctrl.sv]
module segtree_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  segtree_pkg::stat_t stat,
	output segtree_pkg::cmd_t  cmd
);

	segtree_pkg::state_t state_q;
	segtree_pkg::state_t state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= segtree_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			segtree_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = segtree_pkg::ST_IDLE;
				end
			end
			segtree_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = segtree_pkg::ST_DECODE;
				end
			end
			segtree_pkg::ST_DECODE: begin
				if (stat.item_bad) begin
					state_d = segtree_pkg::ST_DONE;
				end else if (stat.op == segtree_pkg::OP_RANGE_SUM) begin
					state_d = segtree_pkg::ST_QUERY;
				end else begin
					state_d = segtree_pkg::ST_LEAF_RD;
				end
			end
			segtree_pkg::ST_LEAF_RD: begin
				cmd.leaf_read = 1'b1;
				state_d = segtree_pkg::ST_LEAF_WR;
			end
			segtree_pkg::ST_LEAF_WR: begin
				cmd.leaf_write = 1'b1;
				state_d = segtree_pkg::ST_UP;
			end
			segtree_pkg::ST_UP: begin
				cmd.up_step = 1'b1;
				if (stat.up_last) begin
					state_d = segtree_pkg::ST_DONE;
				end
			end
			segtree_pkg::ST_QUERY: begin
				// the step that finds the bounds crossed still folds in the last reads
				cmd.q_step = 1'b1;
				if (!stat.q_more) begin
					state_d = segtree_pkg::ST_DONE;
				end
			end
			segtree_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = segtree_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = segtree_pkg::ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_capture_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == segtree_pkg::ST_DECODE)
		else $error("accepted transaction not decoded");

	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrites an undelivered transaction");

	a_bad_skips_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == segtree_pkg::ST_DECODE && stat.item_bad)
		|=> state_q == segtree_pkg::ST_DONE)
		else $error("rejected transaction touched the tree");

endmodule
